@@ hdl/bcc_pkg.sv @@
// Shared types and constants for the button click classifier.
`timescale 1ns / 1ps

package bcc_pkg;

   localparam int unsigned LIMIT_W = 8;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [LIMIT_W-1:0] COUNT_MAX = '1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_WINDOW = 2'd2;

   localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST   = 8'd20;
   localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST    = 8'd50;
   localparam logic [LIMIT_W-1:0] DOUBLE_WINDOW_RST = 8'd50;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_WAIT   = 2'd2,
      MODE_SECOND = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] short_limit;
      logic [LIMIT_W-1:0] long_limit;
      logic [LIMIT_W-1:0] double_window;
   } cfg_type;

   typedef struct packed {
      event_type event_res;
      logic      is_pressed;
   } rsp_type;

endpackage

@@ hdl/bcc_gesture_fsm.sv @@
// Gesture state machine: edge detection, tick counter and event latch.
`timescale 1ns / 1ps

module bcc_gesture_fsm import bcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    pin_level,
   input  logic    take_event,
   input  cfg_type cfg,
   output rsp_type rsp
);

   mode_type           mode_ff, mode_in;
   logic [LIMIT_W-1:0] count_ff, count_in;
   event_type          pending_ff, pending_in;
   logic               prev_ff;

   logic               press, release_edge;
   logic [LIMIT_W-1:0] count_inc;
   event_type          latched;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         count_ff   <= '0;
         pending_ff <= EV_NONE;
         prev_ff    <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         prev_ff    <= pin_level;
      end
   end

   always_comb begin
      press        = prev_ff & ~pin_level;
      release_edge = ~prev_ff & pin_level;
      count_inc    = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

      mode_in  = mode_ff;
      count_in = count_ff;
      latched  = pending_ff;

      unique case (mode_ff)
         MODE_IDLE: begin
            if (press) begin
               mode_in  = MODE_FIRST;
               count_in = '0;
               latched  = EV_NONE;
            end
         end
         MODE_FIRST: begin
            count_in = count_inc;
            if (release_edge) begin
               if (count_inc < cfg.short_limit) begin
                  mode_in  = MODE_WAIT;
                  count_in = '0;
               end else if (count_inc < cfg.long_limit) begin
                  mode_in  = MODE_IDLE;
                  count_in = '0;
                  latched  = EV_SHORT;
               end else begin
                  // release at or past the long limit: no event
                  mode_in  = MODE_IDLE;
                  count_in = '0;
               end
            end else if (count_inc >= cfg.long_limit) begin
               mode_in  = MODE_IDLE;
               count_in = '0;
               latched  = EV_LONG;
            end
         end
         MODE_WAIT: begin
            count_in = count_inc;
            if (press) begin
               mode_in  = MODE_SECOND;
               count_in = '0;
            end else if (count_inc >= cfg.double_window) begin
               mode_in  = MODE_IDLE;
               count_in = '0;
               latched  = EV_SHORT;
            end
         end
         MODE_SECOND: begin
            if (release_edge) begin
               mode_in  = MODE_IDLE;
               count_in = '0;
               latched  = EV_DOUBLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // read and clear after the update
      if (take_event) begin
         rsp.event_res = latched;
         pending_in    = EV_NONE;
      end else begin
         rsp.event_res = EV_NONE;
         pending_in    = latched;
      end
      rsp.is_pressed = ~pin_level;
   end

endmodule

@@ hdl/bcc_out_buf.sv @@
// Result register with a skid stage behind it.
`timescale 1ns / 1ps

module bcc_out_buf import bcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_load,
   input  rsp_type in_data,
   output logic    in_full,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    main_free;

   assign main_free = ~main_valid_ff | ~out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_load;
         end
      end else if (in_load) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end
      if (!main_free && in_load) begin
         skid_ff <= in_data;
      end
   end

   assign in_full   = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

@@ hdl/button_click_classifier_top.sv @@
// Top level of the button click classifier.
`timescale 1ns / 1ps

// Button click classifier: sorts the gestures of one active-low button into
// short clicks, long presses and double clicks.
//
// Request channel (req_valid / req_stall): one request per tick carrying the
// sampled pin level and a flag that reads and clears the latched event.
// Response channel (rsp_valid / rsp_stall): one response per request with the
// event read on that tick and the pressed flag of that tick's level.
// Config port (csr_write_en / csr_index / csr_write_data): index 0 short
// limit, 1 long limit, 2 double-click window; other indexes are dropped.
// Write it only while no request is in flight.
//
// The response is registered; one request is taken every cycle while
// req_stall is low. The gesture state updates in the cycle a request is
// accepted and the response lands in the result register at that edge, or
// in the skid stage while that register holds. When the receiver stalls,
// the result register holds and one further request goes into the skid
// stage; req_stall rises only while that stage is full.
// Synchronous reset returns the machine to idle, clears the counter, the
// latched event and the previous level, restores the limits to 20, 50 and 50
// and empties both output stages.

module button_click_classifier_top import bcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_pin_level,
   input  logic                 req_take_event,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_event_res,
   output logic                 rsp_is_pressed,
   // configuration writes
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_write_data
);

   cfg_type cfg_ff;
   logic    req_accept;
   rsp_type step_rsp;
   rsp_type out_rsp;

   // Config registers; unknown indexes fall through untouched.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_limit   <= SHORT_LIMIT_RST;
         cfg_ff.long_limit    <= LONG_LIMIT_RST;
         cfg_ff.double_window <= DOUBLE_WINDOW_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SHORT_LIMIT:   cfg_ff.short_limit   <= csr_write_data;
            CSR_LONG_LIMIT:    cfg_ff.long_limit    <= csr_write_data;
            CSR_DOUBLE_WINDOW: cfg_ff.double_window <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Advance the gesture machine only on an accepted request.
   assign req_accept = req_valid & ~req_stall;

   bcc_gesture_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .pin_level  (req_pin_level),
      .take_event (req_take_event),
      .cfg        (cfg_ff),
      .rsp        (step_rsp)
   );

   bcc_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_load   (req_accept),
      .in_data   (step_rsp),
      .in_full   (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_rsp)
   );

   assign rsp_event_res  = out_rsp.event_res;
   assign rsp_is_pressed = out_rsp.is_pressed;

endmodule

@@ hdl/bcc_checker.sv @@
// Port-level checks for the button click classifier, bound to the top level.
`timescale 1ns / 1ps

module bcc_checker import bcc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 req_pin_level,
   input logic                 req_take_event,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [1:0]           rsp_event_res,
   input logic                 rsp_is_pressed
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_is_pressed))
      else $error("stalled response changed");

   // Back-pressure on requests only while a response is waiting.
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // With the output empty, a request shows up on the next cycle.
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=>
         rsp_valid && (rsp_is_pressed == !$past(req_pin_level))
         && (!$past(req_take_event) ? rsp_event_res == EV_NONE : 1'b1))
      else $error("response missing or wrong after request");

   // Reset empties both output stages.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind button_click_classifier_top bcc_checker u_checker (.*);
